// ----- hw/rtl/crra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crra_pkg;

   localparam int WORD_W    = 32;
   localparam int MAX_RANGE = 32;
   localparam int IDX_W     = 8;
   localparam int CNT_W     = 6;
   localparam int HW_W      = 9;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLAIM = 2'd2
   } req_op_type;

   typedef enum logic [1:0] {
      RC_DONE    = 2'd0,
      RC_NO_ROOM = 2'd1,
      RC_INVALID = 2'd2
   } rsp_code_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_SET_LO,
      WR_SET_HI,
      WR_CLR_LO,
      WR_CLR_HI,
      WR_SET_BIT
   } wr_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SPAN,
      S_COMMIT,
      S_FREE_LO,
      S_FREE_HI,
      S_CLAIM,
      S_FINISH
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [IDX_W-1:0] entry_index;
      logic [CNT_W-1:0] range_count;
   } crra_req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] base_index;
      logic [HW_W-1:0]  high_water;
   } crra_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic         load_req;
      logic         ptr_clear;
      logic         ptr_inc;
      logic         word_sel;    // 0: word at pointer, 1: next word
      logic         latch_bit;
      wr_op_type    wr_op;
      logic         raise_mark;
      logic         load_rsp;
      rsp_code_type rsp_code;
      logic         rsp_base;
   } crra_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_kind;
      logic       count_ok;
      logic       free_ok;
      logic       claim_ok;
      logic       hit;
      logic       fits;
      logic       last_word;
      logic       span_ok;
      logic       spans;
      logic       bit_used;
      logic       rsp_busy;
   } crra_stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/crra_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crra_datapath #(
   parameter int NUM_ENTRIES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire crra_pkg::crra_req_type req_item,
   input  wire crra_pkg::crra_cmd_type cmd,
   output crra_pkg::crra_stat_type     stat,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output crra_pkg::crra_rsp_type      rsp_item
);
   import crra_pkg::*;

   localparam int NUM_WORDS = NUM_ENTRIES / WORD_W;
   localparam int WIDX      = $clog2(NUM_WORDS);
   localparam int MW        = WIDX + 6;

   logic [WORD_W-1:0] map_ff [NUM_WORDS];

   crra_req_type      req_ff;
   logic [WIDX-1:0]   ptr_ff, ptr_in;
   logic [4:0]        bit_ff, bit_in;
   logic [MW-1:0]     mark_ff, mark_in;
   logic              rsp_valid_ff, rsp_valid_in;
   crra_rsp_type      rsp_ff, rsp_in;

   logic [WIDX-1:0]   rd_addr;
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] mask;
   logic [2*WORD_W-1:0] placed;
   logic [WORD_W-1:0] lo_bits, hi_bits, one_bit;
   logic [WORD_W-1:0] wr_data_in;
   logic [4:0]        start;
   logic              hit;
   logic [4:0]        hit_bit;
   logic [WORD_W-1:0] shifted;
   logic [MW-1:0]     run_end;

   assign rd_addr = cmd.word_sel ? ptr_ff + WIDX'(1) : ptr_ff;
   assign rd_word = map_ff[rd_addr];

   assign mask = (req_ff.range_count >= CNT_W'(MAX_RANGE)) ? '1 :
                 (WORD_W'(1) << req_ff.range_count) - WORD_W'(1);
   assign placed  = {{WORD_W{1'b0}}, mask} << bit_ff;
   assign lo_bits = placed[WORD_W-1:0];
   assign hi_bits = placed[2*WORD_W-1:WORD_W];
   assign one_bit = WORD_W'(1) << bit_ff;

   // first-fit search inside one word, skipping full low bytes
   always_comb begin
      if (rd_word[15:0] == 16'hFFFF) begin
         start = (rd_word[23:16] == 8'hFF) ? 5'd24 : 5'd16;
      end else begin
         start = (rd_word[7:0] == 8'hFF) ? 5'd8 : 5'd0;
      end
      hit     = 1'b0;
      hit_bit = '0;
      shifted = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         shifted = rd_word >> b;
         if (5'(b) >= start && (shifted & mask) == '0) begin
            hit     = 1'b1;
            hit_bit = 5'(b);
         end
      end
   end

   always_comb begin
      case (cmd.wr_op)
         WR_SET_LO:  wr_data_in = rd_word | lo_bits;
         WR_SET_HI:  wr_data_in = rd_word | hi_bits;
         WR_CLR_LO:  wr_data_in = rd_word & ~lo_bits;
         WR_CLR_HI:  wr_data_in = rd_word & ~hi_bits;
         WR_SET_BIT: wr_data_in = rd_word | one_bit;
         default:    wr_data_in = rd_word;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WORDS; i++) begin
            map_ff[i] <= '0;
         end
      end else if (cmd.wr_op != WR_NONE) begin
         map_ff[rd_addr] <= wr_data_in;
      end
   end

   assign run_end = {1'b0, ptr_ff, bit_ff} + MW'(req_ff.range_count);

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load_req) begin
         ptr_in = WIDX'(req_item.entry_index[IDX_W-1:5]);
      end else if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + WIDX'(1);
      end

      bit_in = bit_ff;
      if (cmd.load_req) begin
         bit_in = req_item.entry_index[4:0];
      end else if (cmd.latch_bit) begin
         bit_in = hit_bit;
      end

      mark_in = mark_ff;
      if (cmd.raise_mark && run_end > mark_ff) begin
         mark_in = run_end;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = cmd.rsp_code;
         rsp_in.base_index = cmd.rsp_base ? IDX_W'({ptr_ff, bit_ff}) : '0;
         rsp_in.high_water = HW_W'(mark_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mark_ff      <= mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
      ptr_ff <= ptr_in;
      bit_ff <= bit_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      stat.req_kind  = req_ff.req_type;
      stat.count_ok  = req_ff.range_count != '0 &&
                       req_ff.range_count <= CNT_W'(MAX_RANGE);
      stat.free_ok   = stat.count_ok &&
                       (int'(req_ff.entry_index) + int'(req_ff.range_count)
                        <= NUM_ENTRIES);
      stat.claim_ok  = int'(req_ff.entry_index) < NUM_ENTRIES;
      stat.hit       = hit;
      stat.fits      = 7'(hit_bit) + 7'(req_ff.range_count) <= 7'(WORD_W);
      stat.last_word = ptr_ff == WIDX'(NUM_WORDS - 1);
      stat.span_ok   = (rd_word & hi_bits) == '0;
      stat.spans     = hi_bits != '0;
      stat.bit_used  = rd_word[bit_ff];
      stat.rsp_busy  = rsp_valid_ff && rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.status != 2'd3)
      else $error("result status code out of range");

   a_base_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status == RC_DONE || rsp_ff.base_index == '0))
      else $error("base index set on a failed request");

   a_mark_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> mark_ff >= $past(mark_ff))
      else $error("high-water mark went down");

   a_hi_word_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op == WR_SET_HI || cmd.wr_op == WR_CLR_HI) |-> !stat.last_word)
      else $error("upper-word write past the last bitmap word");

endmodule

`default_nettype wire

// ----- hw/rtl/crra_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crra_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire crra_pkg::crra_stat_type stat,
   output crra_pkg::crra_cmd_type       cmd
);
   import crra_pkg::*;

   fsm_state_type state_ff, state_in;
   rsp_code_type  code_ff, code_in;
   logic          base_ff, base_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= RC_INVALID;
         base_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         base_ff  <= base_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      base_in      = base_ff;
      cmd          = '0;
      cmd.wr_op    = WR_NONE;
      cmd.rsp_code = code_ff;
      req_stall    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               code_in      = RC_INVALID;
               base_in      = 1'b0;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            case (stat.req_kind)
               OP_ALLOC: if (stat.count_ok) begin
                  cmd.ptr_clear = 1'b1;
                  state_in      = S_SCAN;
               end
               OP_FREE:  if (stat.free_ok) state_in = S_FREE_LO;
               OP_CLAIM: if (stat.claim_ok) state_in = S_CLAIM;
               default:  state_in = S_FINISH;
            endcase
         end
         S_SCAN: begin
            cmd.latch_bit = 1'b1;
            if (stat.hit && stat.fits) begin
               state_in = S_COMMIT;
            end else if (stat.hit && !stat.last_word) begin
               state_in = S_SPAN;
            end else if (stat.last_word) begin
               code_in  = RC_NO_ROOM;
               state_in = S_FINISH;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_SPAN: begin
            cmd.word_sel = 1'b1;
            if (stat.span_ok) begin
               cmd.wr_op = WR_SET_HI;
               state_in  = S_COMMIT;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_COMMIT: begin
            cmd.wr_op      = WR_SET_LO;
            cmd.raise_mark = 1'b1;
            code_in        = RC_DONE;
            base_in        = 1'b1;
            state_in       = S_FINISH;
         end
         S_FREE_LO: begin
            cmd.wr_op = WR_CLR_LO;
            code_in   = RC_DONE;
            state_in  = stat.spans ? S_FREE_HI : S_FINISH;
         end
         S_FREE_HI: begin
            cmd.word_sel = 1'b1;
            cmd.wr_op    = WR_CLR_HI;
            state_in     = S_FINISH;
         end
         S_CLAIM: begin
            if (stat.bit_used) begin
               code_in = RC_NO_ROOM;
            end else begin
               cmd.wr_op = WR_SET_BIT;
               code_in   = RC_DONE;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               cmd.rsp_code = code_ff;
               cmd.rsp_base = base_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !stat.rsp_busy)
      else $error("result register loaded while still held");

endmodule

`default_nettype wire

// ----- hw/rtl/contiguous_register_range_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                              Moves
// --------  ---------------------------------  ------------------------------------
// request   req_valid / req_stall / req_item   one item: allocate, free or claim
// response  rsp_valid / rsp_stall / rsp_item   one item per request, in order
//
// Steps: allocate decodes, scans the bitmap reading one word per cycle, checks the
//   next word when a run spills into it, commits (not on no room) and hands off
//   the result; free clears the lower word and, when the range crosses a word, the
//   upper one; claim tests and sets one bit; a rejected request goes to the result.
// Reset: synchronous; clears the in-use bitmap, the high-water mark and control.
// Stalls: one item is in work at a time; a finished item waits in the output
//   register while the next request is already taken.

module contiguous_register_range_allocator #(
   parameter int NUM_ENTRIES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire crra_pkg::crra_req_type req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output crra_pkg::crra_rsp_type      rsp_item
);
   import crra_pkg::*;

   crra_cmd_type  cmd;
   crra_stat_type stat;

   // sequencer: decode, word-by-word scan, commit, free, claim, result hand-off
   crra_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bitmap words, first-fit search, high-water mark and output register
   crra_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ----- test/tb_contiguous_register_range_allocator.sv -----
`timescale 1ns / 1ps

module tb_contiguous_register_range_allocator;
   import crra_pkg::*;

   localparam int NUM_ENTRIES    = 256;
   localparam int NUM_WORDS      = NUM_ENTRIES / WORD_W;
   localparam int RANDOM_ITEMS   = 2000;
   // sized from the worst allocate; leave plenty of slack at the end
   localparam int DRAIN_CYCLES   = 4 * (2 * NUM_WORDS + 3);
   // longest quiet stretch is a long gap plus one item plus a long stall
   localparam int WATCHDOG_LIMIT = 2000;

   // request type with no package name; the block must reject it
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   // bitmap of used entries plus the high-water mark
   typedef struct packed {
      logic [NUM_WORDS-1:0][WORD_W-1:0] words;
      logic [HW_W-1:0]                  mark;
   } entry_map_type;

   typedef struct packed {
      entry_map_type map;
      crra_rsp_type  rsp;
   } map_update_type;

   typedef struct {
      int first;
      int count;
   } held_range_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   crra_req_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   crra_rsp_type rsp_item;

   crra_req_type   request_queue[$];   // items waiting for the driver
   crra_rsp_type   awaited_rsp[$];     // predicted responses, oldest first
   held_range_type held_ranges[$];     // ranges the stimulus may hand back

   entry_map_type  bitmap_now  = '0;   // tracks the block, advanced on accept
   entry_map_type  bitmap_plan = '0;   // tracks the stimulus as it is built

   int req_gap_left  = 0;
   int rsp_hold_left = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int level_cycles  = 0;
   int quiet_cycles  = 0;
   int mismatches    = 0;
   int rsp_seq       = 0;

   int n_alloc = 0, n_free = 0, n_claim = 0, n_other = 0;
   int n_done = 0, n_no_room = 0, n_invalid = 0;

   contiguous_register_range_allocator #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor: one request in, new bitmap and the response out.
   // Allocation is first fit, word by word; within a word the search
   // starts past full low bytes (0, 8, 16 or 24). A run may spill into
   // the next word only; if the spill does not fit there, the search
   // gives up on this word and goes on with the next one.
   // ------------------------------------------------------------------
   function automatic map_update_type apply_request(entry_map_type m, crra_req_type rq);
      map_update_type res;
      logic [31:0]   mask;
      logic [31:0]   bits;
      logic [31:0]   upper;
      int            cnt;
      int            idx;
      int            start;
      int            base;
      int            wi;
      int            bi;
      bit            found;

      res.rsp = '0;
      cnt     = int'(rq.range_count);
      idx     = int'(rq.entry_index);
      mask    = (cnt >= WORD_W) ? '1 : ((32'd1 << cnt) - 32'd1);
      base    = 0;
      found   = 1'b0;
      res.rsp.status = RC_INVALID;

      if (rq.req_type == OP_ALLOC) begin
         if (cnt >= 1 && cnt <= MAX_RANGE) begin
            for (int w = 0; w < NUM_WORDS && !found; w++) begin
               bits = m.words[w];
               if (bits == '1) continue;
               if (bits[15:0] == 16'hFFFF) start = (bits[23:16] == 8'hFF) ? 24 : 16;
               else start = (bits[7:0] == 8'hFF) ? 8 : 0;
               for (int b = start; b < WORD_W; b++) begin
                  if (((bits >> b) & mask) != '0) continue;
                  if (b + cnt <= WORD_W) begin
                     m.words[w] |= mask << b;
                     base  = w * WORD_W + b;
                     found = 1'b1;
                     break;
                  end
                  if (w + 1 >= NUM_WORDS) break;
                  upper = mask >> (WORD_W - b);
                  if ((m.words[w+1] & upper) == '0) begin
                     m.words[w]   |= mask << b;
                     m.words[w+1] |= upper;
                     base  = w * WORD_W + b;
                     found = 1'b1;
                  end
                  break;   // spill failed: straight on to the next word
               end
            end
            if (found) begin
               res.rsp.status     = RC_DONE;
               res.rsp.base_index = IDX_W'(base);
               if (base + cnt > int'(m.mark)) m.mark = HW_W'(base + cnt);
            end else begin
               res.rsp.status = RC_NO_ROOM;
            end
         end
      end else if (rq.req_type == OP_FREE) begin
         if (cnt >= 1 && cnt <= MAX_RANGE && idx + cnt <= NUM_ENTRIES) begin
            wi = idx / WORD_W;
            bi = idx % WORD_W;
            m.words[wi] &= ~(mask << bi);
            if (bi + cnt > WORD_W && wi + 1 < NUM_WORDS)
               m.words[wi+1] &= ~(mask >> (WORD_W - bi));
            res.rsp.status = RC_DONE;
         end
      end else if (rq.req_type == OP_CLAIM) begin
         if (idx < NUM_ENTRIES) begin
            wi = idx / WORD_W;
            bi = idx % WORD_W;
            if (m.words[wi][bi]) begin
               res.rsp.status = RC_NO_ROOM;
            end else begin
               m.words[wi][bi] = 1'b1;
               res.rsp.status  = RC_DONE;
            end
         end
      end
      // unknown type falls through as invalid with no change

      res.rsp.high_water = m.mark;
      res.map = m;
      return res;
   endfunction

   // idle level for a stretch of cycles: none, light or heavy
   function automatic int pick_level();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 25;
         default: return 70;
      endcase
   endfunction

   // gap or stall length: mostly short, now and then long
   function automatic int pick_pause(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // range sizes: mostly small, some medium, a few full words
   function automatic int pick_count();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(1, 8);
      if (r < 9) return $urandom_range(9, MAX_RANGE - 1);
      return MAX_RANGE;
   endfunction

   // queue one item and follow it in the planning copy so later frees
   // can target ranges that really got handed out
   task automatic plan_request(input logic [1:0] op, input int idx, input int cnt);
      crra_req_type   rq;
      map_update_type nx;
      rq.req_type    = op;
      rq.entry_index = IDX_W'(idx);
      rq.range_count = CNT_W'(cnt);
      request_queue = {request_queue, rq};
      nx = apply_request(bitmap_plan, rq);
      bitmap_plan = nx.map;
      if (nx.rsp.status == RC_DONE && op == OP_ALLOC)
         held_ranges = {held_ranges, held_range_type'{int'(nx.rsp.base_index), cnt}};
      if (nx.rsp.status == RC_DONE && op == OP_CLAIM)
         held_ranges = {held_ranges, held_range_type'{idx, 1}};
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t: response %0d, %s: got 0x%0h, expected 0x%0h",
               $time, rsp_seq, what, got, want);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // Driver: presents queued items, holds each one while stalled, and
   // predicts the response the moment an item is taken.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      map_update_type nx;
      if (reset) begin
         req_valid    <= 1'b0;
         req_gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            nx = apply_request(bitmap_now, req_item);
            bitmap_now = nx.map;
            awaited_rsp = {awaited_rsp, nx.rsp};
            case (req_item.req_type)
               OP_ALLOC: n_alloc++;
               OP_FREE:  n_free++;
               OP_CLAIM: n_claim++;
               default:  n_other++;
            endcase
         end
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_valid    <= 1'b0;
               req_gap_left <= req_gap_left - 1;
            end else if (request_queue.size() > 0) begin
               req_item     <= request_queue.pop_front();
               req_valid    <= 1'b1;
               req_gap_left <= pick_pause(req_idle_pct);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random backpressure, field-by-field compare on accept.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      crra_rsp_type want;
      if (reset) begin
         rsp_stall     <= 1'b0;
         rsp_hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               flag_mismatch("unexpected response", int'(rsp_item), 0);
            end else begin
               want = awaited_rsp.pop_front();
               if (rsp_item.status != want.status)
                  flag_mismatch("status", rsp_item.status, want.status);
               if (rsp_item.base_index != want.base_index)
                  flag_mismatch("base_index", rsp_item.base_index, want.base_index);
               if (rsp_item.high_water != want.high_water)
                  flag_mismatch("high_water", rsp_item.high_water, want.high_water);
               case (want.status)
                  RC_DONE:    n_done++;
                  RC_NO_ROOM: n_no_room++;
                  default:    n_invalid++;
               endcase
            end
            rsp_seq++;
         end
         if (rsp_hold_left > 0) begin
            rsp_stall     <= 1'b1;
            rsp_hold_left <= rsp_hold_left - 1;
         end else begin
            rsp_stall     <= 1'b0;
            rsp_hold_left <= pick_pause(rsp_idle_pct);
         end
      end
   end

   // idle levels for the two sides are picked independently of each other
   always @(posedge clock) begin
      if (level_cycles == 0) begin
         req_idle_pct <= pick_level();
         rsp_idle_pct <= pick_level();
         level_cycles <= 300;
      end else begin
         level_cycles <= level_cycles - 1;
      end
   end

   // no handshake on either side for too long: give up
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, awaited_rsp.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int alloc_pct;
      int r;
      int pick;

      // directed: bad counts, a word-spanning run, claims, bad frees
      plan_request(OP_ALLOC, 0, 0);            // zero count
      plan_request(OP_ALLOC, 255, 33);         // one past the max
      plan_request(OP_ALLOC, 0, 63);           // largest encodable count
      plan_request(OP_ALLOC, 255, 1);          // lands on entry 0
      plan_request(OP_ALLOC, 0, MAX_RANGE);    // runs from word 0 into word 1
      plan_request(OP_ALLOC, 128, 7);          // word 0 now full, skipped
      plan_request(OP_CLAIM, 255, 0);          // far above the high-water mark
      plan_request(OP_CLAIM, 255, 63);         // same entry again: already used
      plan_request(OP_CLAIM, 40, 1);
      plan_request(OP_FREE, 250, 10);          // runs past the last entry
      plan_request(OP_FREE, 0, 0);             // zero count
      plan_request(OP_FREE, 0, 40);            // count too big
      plan_request(OP_FREE, 100, 5);           // already free, still fine
      plan_request(OP_UNKNOWN, 255, 63);
      plan_request(OP_UNKNOWN, 0, 0);
      plan_request(OP_FREE, 224, MAX_RANGE);   // ends exactly at the top
      plan_request(OP_FREE, 0, MAX_RANGE);     // frees all of word 0
      plan_request(OP_ALLOC, 0, MAX_RANGE);
      for (int i = 0; i < 7; i++)              // keep going until no room
         plan_request(OP_ALLOC, 255, MAX_RANGE);

      // random: phases biased toward filling, churn or draining the map
      held_ranges.delete();
      for (int i = 0; i < NUM_WORDS; i++)
         plan_request(OP_FREE, i * WORD_W, MAX_RANGE);
      alloc_pct = 45;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       alloc_pct = 85;
               1:       alloc_pct = 45;
               default: alloc_pct = 15;
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < 5) begin
            // raw noise across every field
            plan_request(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                         $urandom_range(0, 63));
         end else if (r < 7 && alloc_pct == 15) begin
            // wipe the whole map
            for (int i = 0; i < NUM_WORDS; i++)
               plan_request(OP_FREE, i * WORD_W, MAX_RANGE);
            held_ranges.delete();
         end else begin
            r = $urandom_range(0, 99);
            if (r < alloc_pct || held_ranges.size() == 0) begin
               plan_request(OP_ALLOC, $urandom_range(0, 255), pick_count());
            end else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4) begin
               pick = $urandom_range(0, held_ranges.size() - 1);
               plan_request(OP_FREE, held_ranges[pick].first, held_ranges[pick].count);
               held_ranges.delete(pick);
            end else begin
               plan_request(OP_CLAIM, $urandom_range(0, 255), $urandom_range(0, 63));
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_valid) @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d allocate, %0d free, %0d claim, %0d of unknown type.",
               n_alloc + n_free + n_claim + n_other, n_alloc, n_free, n_claim, n_other);
      $display("Outcomes checked: %0d done, %0d no room or in use, %0d invalid; %0d mismatches.",
               n_done, n_no_room, n_invalid, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- contiguous_register_range_allocator.f -----
hw/rtl/crra_pkg.sv
hw/rtl/crra_datapath.sv
hw/rtl/crra_controller.sv
hw/rtl/contiguous_register_range_allocator.sv
test/tb_contiguous_register_range_allocator.sv
